// ===== design/scaled_glyph_rasterizer_unit_assert.svh =====
// Assertion macros used by the checker file of the rasterizer.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef SCALED_GLYPH_RASTERIZER_UNIT_ASSERT_SVH
`define SCALED_GLYPH_RASTERIZER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the following cycle.
`define SGR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sgr_pkg.sv =====
// Shared types, command codes, state encoding and glyph table of the rasterizer.
// No dependencies.
package sgr_pkg;

    localparam int GLYPH_W = 5;
    localparam int GLYPH_H = 7;
    localparam logic [27:0] REPEAT_RESET = 28'h1122211;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_PIXEL  = 3'd1,
        CMD_SCALED = 3'd2,
        CMD_REPEAT = 3'd3,
        CMD_READ   = 3'd4
    } sgr_cmd_code_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_SPAN,
        ST_WRITE,
        ST_RD,
        ST_RD_OUT
    } sgr_state_t;

    // Five columns of seven bits, column 0 in element 0, glyph row 0 in bit 0.
    typedef logic [GLYPH_W-1:0][GLYPH_H-1:0] sgr_glyph_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic span_init;
        logic span_rd;
        logic span_wr;
        logic span_adv;
        logic walk_adv;
        logic byte_rd;
    } sgr_ctl_t;

    typedef struct packed {
        logic clr_last;
        logic empty;
        logic draw_now;
        logic walk_last;
        logic span_hit;
        logic span_last;
    } sgr_sts_t;

    // Concatenations list column 4 first, column 0 last.
    function automatic sgr_glyph_t glyph_lookup(input logic [7:0] code);
        sgr_glyph_t g;
        g = '0;
        unique case (code)
            8'h21:   g = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00}; // !
            8'h2D:   g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08}; // -
            8'h41:   g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}; // A
            8'h44:   g = {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F}; // D
            8'h45:   g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F}; // E
            8'h47:   g = {7'h7A, 7'h49, 7'h49, 7'h41, 7'h3E}; // G
            8'h48:   g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F}; // H
            8'h49:   g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}; // I
            8'h4C:   g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F}; // L
            8'h4D:   g = {7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F}; // M
            8'h4F:   g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}; // O
            8'h50:   g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F}; // P
            8'h52:   g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F}; // R
            8'h53:   g = {7'h31, 7'h49, 7'h49, 7'h49, 7'h46}; // S
            8'h54:   g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01}; // T
            8'h55:   g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}; // U
            8'h56:   g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F}; // V
            8'h63:   g = {7'h28, 7'h44, 7'h44, 7'h44, 7'h38}; // c
            8'h69:   g = {7'h00, 7'h40, 7'h7D, 7'h41, 7'h00}; // i
            8'h6F:   g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38}; // o
            default: g = '0;                                  // space and unknown
        endcase
        return g;
    endfunction

endpackage

// ===== design/sgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sgr_ctrl.sv =====
// Sequencer of the rasterizer: clear sweep, glyph walk, span read-modify-write, byte read.
// Depends on sgr_pkg.
module sgr_ctrl
    import sgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] cmd,
    input  sgr_sts_t   sts,
    output sgr_ctl_t   ctl,
    output logic       busy,
    output logic       done
);

    sgr_state_t state_reg, state_next;
    logic       pixel_op_reg, pixel_op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pixel_op_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pixel_op_reg <= pixel_op_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        pixel_op_next = pixel_op_reg;
        ctl           = '0;
        done          = 1'b0;
        busy          = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        CMD_PIXEL:
                        begin
                            ctl.load      = 1'b1;
                            pixel_op_next = 1'b1;
                            state_next    = ST_SPAN;
                        end
                        CMD_SCALED, CMD_REPEAT:
                        begin
                            ctl.load      = 1'b1;
                            pixel_op_next = 1'b0;
                            state_next    = ST_ROW;
                        end
                        CMD_READ:
                        begin
                            ctl.load   = 1'b1;
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                priority if (sts.empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.draw_now)
                begin
                    ctl.span_init = 1'b1;
                    state_next    = ST_SPAN;
                end
                else
                begin
                    ctl.walk_adv = 1'b1;
                    state_next   = sts.walk_last ? ST_IDLE : ST_ROW;
                end
            end
            ST_SPAN:
            begin
                if (sts.span_hit)
                begin
                    ctl.span_rd = 1'b1;
                    state_next  = ST_WRITE;
                end
                else
                begin
                    // Off-frame chunk: drop it and move on
                    ctl.span_adv = 1'b1;
                    if (sts.span_last)
                    begin
                        if (pixel_op_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            ctl.walk_adv = 1'b1;
                            state_next   = sts.walk_last ? ST_IDLE : ST_ROW;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                ctl.span_wr  = 1'b1;
                ctl.span_adv = 1'b1;
                if (sts.span_last)
                begin
                    if (pixel_op_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ctl.walk_adv = 1'b1;
                        state_next   = sts.walk_last ? ST_IDLE : ST_ROW;
                    end
                end
                else
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_RD:
            begin
                ctl.byte_rd = 1'b1;
                state_next  = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/sgr_datapath.sv =====
// Datapath of the rasterizer: item registers, glyph walk counters, span masks,
// frame store addressing and the frame store itself. Depends on sgr_pkg, sgr_ram.
module sgr_datapath
    import sgr_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [27:0] cfg_wr_data,
    input  logic [2:0]  cmd,
    input  logic [7:0]  x_pos,
    input  logic [7:0]  y_pos,
    input  logic [7:0]  char_code,
    input  logic [3:0]  scale_x,
    input  logic [3:0]  scale_y,
    input  logic        pixel_on,
    input  logic [8:0]  read_index,
    input  sgr_ctl_t    ctl,
    output sgr_sts_t    sts,
    output logic [7:0]  frame_byte
);

    localparam int PAGE_COUNT = (FRAME_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = FRAME_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int LAST_ROWS  = FRAME_HEIGHT - (PAGE_COUNT - 1) * 8;
    localparam logic [8:0] LAST_MASK_W = (9'd1 << LAST_ROWS) - 9'd1;
    localparam logic [7:0] LAST_MASK   = LAST_MASK_W[7:0];

    logic [27:0]       repeat_reg;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic [7:0]  x_cur_reg, x_cur_next;
    logic [7:0]  y_base_reg, y_base_next;
    logic [7:0]  y_row_reg, y_row_next;
    logic [7:0]  cur_y_reg, cur_y_next;
    logic [3:0]  remain_reg, remain_next;
    logic [2:0]  col_reg, col_next;
    logic [2:0]  row_reg, row_next;
    logic [3:0]  dx_reg, dx_next;
    logic [3:0]  sx_reg, sx_next;
    logic [3:0]  sy_reg, sy_next;
    logic        rep_mode_reg, rep_mode_next;
    logic        set_reg, set_next;
    sgr_glyph_t  glyph_reg, glyph_next;
    logic [8:0]  rd_idx_reg, rd_idx_next;

    logic [3:0]        row_h;
    logic [2:0]        y_off;
    logic [3:0]        room;
    logic [3:0]        chunk;
    logic [4:0]        page;
    logic [8:0]        ones;
    logic [7:0]        mask_raw;
    logic [7:0]        mask;
    logic [ADDR_W-1:0] span_addr;
    logic [ADDR_W-1:0] byte_addr;
    logic              rd_ok;
    logic              row_end;
    logic              dx_end;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    // Height of the current glyph row
    assign row_h = rep_mode_reg ? repeat_reg[{row_reg, 2'b00} +: 4] : sy_reg;

    // Chunk of the span that stays within one page
    assign y_off     = cur_y_reg[2:0];
    assign room      = 4'd8 - {1'b0, y_off};
    assign chunk     = (remain_reg <= room) ? remain_reg : room;
    assign page      = cur_y_reg[7:3];
    assign ones      = (9'd1 << chunk) - 9'd1;
    assign mask_raw  = 8'(ones << y_off);
    assign mask      = (int'(page) == PAGE_COUNT - 1) ? (mask_raw & LAST_MASK) : mask_raw;
    assign span_addr = ADDR_W'(int'(page) * FRAME_WIDTH + int'(x_cur_reg));
    assign byte_addr = ADDR_W'(rd_idx_reg);
    assign rd_ok     = (int'(rd_idx_reg) < STORE_SIZE);

    assign row_end = (row_reg == 3'(GLYPH_H - 1));
    assign dx_end  = (dx_reg == sx_reg - 4'd1);

    always_comb
    begin
        sts.clr_last  = (clr_addr_reg == ADDR_W'(STORE_SIZE - 1));
        sts.empty     = (sx_reg == 4'd0) || (!rep_mode_reg && (sy_reg == 4'd0));
        sts.draw_now  = glyph_reg[col_reg][row_reg] && (row_h != 4'd0);
        sts.walk_last = row_end && dx_end && (col_reg == 3'(GLYPH_W - 1));
        sts.span_hit  = (int'(x_cur_reg) < FRAME_WIDTH) && (int'(page) < PAGE_COUNT);
        sts.span_last = (remain_reg <= room);
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        x_cur_next    = x_cur_reg;
        y_base_next   = y_base_reg;
        y_row_next    = y_row_reg;
        cur_y_next    = cur_y_reg;
        remain_next   = remain_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        dx_next       = dx_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        rep_mode_next = rep_mode_reg;
        set_next      = set_reg;
        glyph_next    = glyph_reg;
        rd_idx_next   = rd_idx_reg;

        if (ctl.clr_step)
        begin
            clr_addr_next = sts.clr_last ? '0 : clr_addr_reg + ADDR_W'(1);
        end

        if (ctl.load)
        begin
            x_cur_next    = x_pos;
            y_base_next   = y_pos;
            y_row_next    = y_pos;
            cur_y_next    = y_pos;
            remain_next   = 4'd1;
            col_next      = '0;
            row_next      = '0;
            dx_next       = '0;
            sx_next       = scale_x;
            sy_next       = scale_y;
            rep_mode_next = (cmd == CMD_REPEAT);
            set_next      = (cmd != CMD_PIXEL) || pixel_on;
            glyph_next    = glyph_lookup(char_code);
            rd_idx_next   = read_index;
        end

        if (ctl.span_init)
        begin
            cur_y_next  = y_row_reg;
            remain_next = row_h;
        end

        if (ctl.span_adv)
        begin
            cur_y_next  = cur_y_reg + {4'd0, chunk};
            remain_next = remain_reg - chunk;
        end

        // Rows run fastest, then the horizontal repeat, then glyph columns
        if (ctl.walk_adv)
        begin
            if (row_end)
            begin
                row_next   = '0;
                y_row_next = y_base_reg;
                x_cur_next = x_cur_reg + 8'd1;
                if (dx_end)
                begin
                    dx_next  = '0;
                    col_next = col_reg + 3'd1;
                end
                else
                begin
                    dx_next = dx_reg + 4'd1;
                end
            end
            else
            begin
                row_next   = row_reg + 3'd1;
                y_row_next = y_row_reg + {4'd0, row_h};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_reg   <= REPEAT_RESET;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                repeat_reg <= cfg_wr_data;
            end
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_cur_reg    <= x_cur_next;
        y_base_reg   <= y_base_next;
        y_row_reg    <= y_row_next;
        cur_y_reg    <= cur_y_next;
        remain_reg   <= remain_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        dx_reg       <= dx_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        rep_mode_reg <= rep_mode_next;
        set_reg      <= set_next;
        glyph_reg    <= glyph_next;
        rd_idx_reg   <= rd_idx_next;
    end

    assign mem_we    = ctl.clr_step || ctl.span_wr;
    assign mem_waddr = ctl.clr_step ? clr_addr_reg : span_addr;
    assign mem_wdata = ctl.clr_step ? 8'h00
                     : (set_reg ? (mem_rdata | mask) : (mem_rdata & ~mask));
    assign mem_re    = ctl.span_rd || ctl.byte_rd;
    assign mem_raddr = ctl.byte_rd ? byte_addr : span_addr;

    sgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign frame_byte = rd_ok ? mem_rdata : 8'h00;

endmodule

// ===== design/scaled_glyph_rasterizer_unit.sv =====
// Top level of the scaled 5x7 glyph rasterizer over a page-organized frame store.
// Depends on sgr_pkg, sgr_ctrl, sgr_datapath (which holds sgr_ram).
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  command   | start / busy         | cmd x_pos y_pos char_code scale_x scale_y
//            |                      | pixel_on read_index
//  result    | done (1-cycle pulse) | frame_byte
//  config    | cfg_wr_en            | cfg_wr_data (row repeat counts)
//
// An item is taken on a clock edge with start high and busy low.
// After reset the store is swept to zero, one byte a cycle, all FRAME_WIDTH *
// ceil(FRAME_HEIGHT/8) bytes (512 by default) with busy high; the clear
// command runs the same sweep. A read passes the read state and pulses done
// in the output state. A pixel write reads its byte in the span state and
// writes it in the write state, or only passes the span state off the frame.
// A glyph visits the row state once per glyph row per drawn column (35 *
// scale_x), plus the span and write states per page-sized piece of a lit
// block in the frame and the span state per piece off it. A zero scale_x, or
// zero scale_y when scaled, draws nothing; unused commands keep busy low.
// done is not held: the receiver has no way to stall a result.
module scaled_glyph_rasterizer_unit
    import sgr_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [7:0]  x_pos,
    input  logic [7:0]  y_pos,
    input  logic [7:0]  char_code,
    input  logic [3:0]  scale_x,
    input  logic [3:0]  scale_y,
    input  logic        pixel_on,
    input  logic [8:0]  read_index,
    output logic        done,
    output logic [7:0]  frame_byte,
    input  logic        cfg_wr_en,
    input  logic [27:0] cfg_wr_data
);

    sgr_ctl_t ctl;
    sgr_sts_t sts;

    // Sequencer: decides every step, the datapath only executes commands
    sgr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // Walk counters, span masks and the frame store
    sgr_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .char_code   (char_code),
        .scale_x     (scale_x),
        .scale_y     (scale_y),
        .pixel_on    (pixel_on),
        .read_index  (read_index),
        .ctl         (ctl),
        .sts         (sts),
        .frame_byte  (frame_byte)
    );

endmodule

// ===== design/sgr_checker.sv =====
// Port-level checks of the rasterizer, bound to the top level.
// Depends on sgr_pkg and scaled_glyph_rasterizer_unit_assert.svh.
`include "scaled_glyph_rasterizer_unit_assert.svh"

module sgr_checker
    import sgr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] cmd,
    input logic       done
);

    logic known_take;

    assign known_take = start && !busy
                        && (cmd == CMD_CLEAR || cmd == CMD_PIXEL || cmd == CMD_SCALED
                            || cmd == CMD_REPEAT || cmd == CMD_READ);

    // A result only comes out of work in progress
    `SGR_ASSERT(a_done_busy, done |-> busy, "done without busy")

    // Every known command raises busy once it is taken
    `SGR_ASSERT_NEXT(a_take_busy, known_take, busy, "taken item did not raise busy")

    // A taken read answers with done in the output state, which follows the read state
    `SGR_ASSERT_NEXT(a_read_lat, start && !busy && cmd == CMD_READ, ##1 done, "read result late")

    // The result pulse lasts one cycle and frees the block
    `SGR_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "done held or busy after read")

endmodule

bind scaled_glyph_rasterizer_unit sgr_checker u_sgr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);

// ===== test/testbench.sv =====
// Self-checking testbench for scaled_glyph_rasterizer_unit: a directed table, then random
// commands in phases with different row repeat counts, checked against a frame store mirror.
// Depends on sgr_pkg and the rasterizer RTL only.
module testbench;
    import sgr_pkg::*;

    localparam int FRAME_W       = 128;
    localparam int FRAME_H       = 32;
    localparam int PAGES         = (FRAME_H + 7) / 8;
    localparam int STORE_BYTES   = FRAME_W * PAGES;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 150;

    // Opcodes past the read command: the block must ignore them.
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // Characters that have a shape, plus the space; everything else renders blank.
    localparam logic [7:0] GLYPH_CODES [21] = '{
        "!", "-", " ", "A", "D", "G", "H", "I", "L", "O", "P",
        "R", "S", "T", "U", "V", "i", "c", "o", "E", "M"
    };

    // Column 0 first; bit r of a column is glyph row r.
    typedef logic [0:GLYPH_W-1][GLYPH_H-1:0] glyph_shape_t;

    // One command item, plus an optional hand-written expectation for reads.
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] code;
        logic [3:0] sx;
        logic [3:0] sy;
        logic       on;
        logic [8:0] ridx;
        logic       typed;
        logic [7:0] want;
    } cmd_row_t;

    localparam int DIRECTED_ROWS = 27;

    // Directed table. Reads with typed = 1 carry a value worked out by hand; the rest
    // take their expectation from the mirror.
    cmd_row_t directed_rows [DIRECTED_ROWS] = '{
        // store is cleared by the sweep after reset
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd0,   1'b1, 8'h00},
        // corner pixels, then clipping on both axes
        '{CMD_PIXEL,  8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b1, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd0,   1'b1, 8'h01},
        '{CMD_PIXEL,  8'd127, 8'd31,  8'd0,   4'd0,  4'd0,  1'b1, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd511, 1'b1, 8'h80},
        '{CMD_PIXEL,  8'd255, 8'd255, 8'd0,   4'd0,  4'd0,  1'b1, 9'd0,   1'b0, 8'h00},
        '{CMD_PIXEL,  8'd128, 8'd0,   8'd0,   4'd0,  4'd0,  1'b1, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd128, 1'b1, 8'h00},
        '{CMD_PIXEL,  8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd0,   1'b1, 8'h00},
        // unit-scale glyph at the origin
        '{CMD_SCALED, 8'd0,   8'd0,   "A",    4'd1,  4'd1,  1'b0, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd0,   1'b1, 8'h7E},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd1,   1'b1, 8'h11},
        // zero scale on either axis draws nothing
        '{CMD_SCALED, 8'd40,  8'd0,   "T",    4'd0,  4'd3,  1'b0, 9'd0,   1'b0, 8'h00},
        '{CMD_SCALED, 8'd40,  8'd0,   "T",    4'd3,  4'd0,  1'b0, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd40,  1'b1, 8'h00},
        // row repeat glyph with the reset counts: rows 2..4 are two pixels tall
        '{CMD_REPEAT, 8'd10,  8'd0,   "!",    4'd1,  4'd0,  1'b0, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd12,  1'b1, 8'hFF},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd140, 1'b1, 8'h02},
        // unused opcodes with pixel-like fields must leave the store alone
        '{CMD_SPARE_5, 8'd1,  8'd1,   8'd0,   4'd1,  4'd1,  1'b1, 9'd1,   1'b0, 8'h00},
        '{CMD_SPARE_6, 8'd1,  8'd1,   8'd0,   4'd1,  4'd1,  1'b1, 9'd1,   1'b0, 8'h00},
        '{CMD_SPARE_7, 8'd1,  8'd1,   8'd0,   4'd1,  4'd1,  1'b1, 9'd1,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd1,   1'b1, 8'h11},
        // full scale near the top of the coordinate range wraps back into the frame
        '{CMD_SCALED, 8'd250, 8'd250, "M",    4'd15, 4'd15, 1'b0, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd137, 1'b0, 8'h00},
        // clear wipes everything drawn so far
        '{CMD_CLEAR,  8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd0,   1'b0, 8'h00},
        '{CMD_READ,   8'd0,   8'd0,   8'd0,   4'd0,  4'd0,  1'b0, 9'd12,  1'b1, 8'h00}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [2:0]  cmd         = '0;
    logic [7:0]  x_pos       = '0;
    logic [7:0]  y_pos       = '0;
    logic [7:0]  char_code   = '0;
    logic [3:0]  scale_x     = '0;
    logic [3:0]  scale_y     = '0;
    logic        pixel_on    = 1'b0;
    logic [8:0]  read_index  = '0;
    logic        cfg_wr_en   = 1'b0;
    logic [27:0] cfg_wr_data = '0;
    logic        busy;
    logic        done;
    logic [7:0]  frame_byte;

    // Mirror of the frame store and of the repeat count register.
    logic [7:0]  frame_mirror [STORE_BYTES];
    logic [27:0] repeat_mirror;
    // Bytes that outstanding reads must return, oldest first.
    logic [7:0]  pending_bytes [$];
    logic [7:0]  want_byte;
    logic [7:0]  recent_x = '0;
    bit          idle_enabled = 1'b1;
    int          mismatches = 0;

    scaled_glyph_rasterizer_unit #(
        .FRAME_WIDTH (FRAME_W),
        .FRAME_HEIGHT(FRAME_H)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .char_code  (char_code),
        .scale_x    (scale_x),
        .scale_y    (scale_y),
        .pixel_on   (pixel_on),
        .read_index (read_index),
        .done       (done),
        .frame_byte (frame_byte),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #10 clk = ~clk;

    // Count every mismatch and print one line for it.
    task automatic report(input string what, input logic [7:0] exp_b, input logic [7:0] got_b);
        mismatches++;
        $display("MISMATCH %s: expected %02h, got %02h at %0t", what, exp_b, got_b, $time);
    endtask

    function automatic glyph_shape_t glyph_shape(input logic [7:0] ch);
        case (ch)
            "!":     return {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
            "-":     return {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
            "A":     return {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
            "D":     return {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
            "G":     return {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
            "H":     return {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            "I":     return {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            "L":     return {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
            "O":     return {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            "P":     return {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
            "R":     return {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
            "S":     return {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
            "T":     return {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            "U":     return {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
            "V":     return {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            "i":     return {7'h00, 7'h41, 7'h7D, 7'h40, 7'h00};
            "c":     return {7'h38, 7'h44, 7'h44, 7'h44, 7'h28};
            "o":     return {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
            "E":     return {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
            "M":     return {7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F};
            default: return '0;
        endcase
    endfunction

    // Wrap both coordinates to 8 bits, drop anything off the frame, then set or clear one bit.
    function automatic void plot(input int px, input int py, input logic on);
        int col;
        int row;
        col = px & 255;
        row = py & 255;
        if (col >= FRAME_W || row >= FRAME_H)
            return;
        frame_mirror[col + (row >> 3) * FRAME_W][row & 7] = on;
    endfunction

    function automatic void fill_block(input int px, input int py, input int w, input int h);
        for (int dx = 0; dx < w; dx++)
            for (int dy = 0; dy < h; dy++)
                plot(px + dx, py + dy, 1'b1);
    endfunction

    function automatic void draw_scaled_glyph(input cmd_row_t it);
        glyph_shape_t g;
        int sx;
        int sy;
        g  = glyph_shape(it.code);
        sx = it.sx;
        sy = it.sy;
        for (int col = 0; col < GLYPH_W; col++)
            for (int row = 0; row < GLYPH_H; row++)
                if (g[col][row])
                    fill_block(it.x + col * sx, it.y + row * sy, sx, sy);
    endfunction

    // Each glyph row gets the height in its nibble of the repeat register; zero skips it.
    function automatic void draw_repeat_glyph(input cmd_row_t it);
        glyph_shape_t g;
        int sx;
        int rep;
        int yoff;
        g    = glyph_shape(it.code);
        sx   = it.sx;
        yoff = 0;
        for (int row = 0; row < GLYPH_H; row++)
        begin
            rep = repeat_mirror[4*row +: 4];
            if (rep == 0)
                continue;
            for (int col = 0; col < GLYPH_W; col++)
                if (g[col][row])
                    fill_block(it.x + col * sx, it.y + yoff, sx, rep);
            yoff = (yoff + rep) & 255;
        end
    endfunction

    // Advance the mirror by one accepted item; a read queues the byte it must return.
    function automatic void apply_item(input cmd_row_t it);
        logic [7:0] b;
        case (it.op)
            CMD_CLEAR:  foreach (frame_mirror[i]) frame_mirror[i] = '0;
            CMD_PIXEL:  plot(it.x, it.y, it.on);
            CMD_SCALED: draw_scaled_glyph(it);
            CMD_REPEAT: draw_repeat_glyph(it);
            CMD_READ:
            begin
                b = (it.ridx < STORE_BYTES) ? frame_mirror[it.ridx] : 8'h00;
                pending_bytes.push_back(it.typed ? it.want : b);
            end
            default: ;
        endcase
    endfunction

    // Mostly small scales keep glyph draws short; a few reach the full range.
    function automatic logic [3:0] pick_scale();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5)
            return 4'd0;
        if (p < 85)
            return 4'($urandom_range(1, 3));
        return 4'($urandom_range(0, 15));
    endfunction

    // Random item, aimed mostly at the visible frame and at columns drawn just before,
    // with a share of full-range values so every field bit toggles.
    function automatic cmd_row_t random_item();
        cmd_row_t it;
        int pick;
        it   = '0;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            it.op = CMD_CLEAR;
        else if (pick < 6)
            it.op = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
        else if (pick < 26)
            it.op = CMD_PIXEL;
        else if (pick < 46)
            it.op = CMD_SCALED;
        else if (pick < 62)
            it.op = CMD_REPEAT;
        else
            it.op = CMD_READ;
        it.x = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, FRAME_W + 7)) : 8'($urandom);
        it.y = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, FRAME_H + 7)) : 8'($urandom);
        it.code = ($urandom_range(0, 3) != 0) ? GLYPH_CODES[$urandom_range(0, 20)]
                                              : 8'($urandom);
        it.sx = pick_scale();
        it.sy = pick_scale();
        it.on = 1'($urandom);
        if ($urandom_range(0, 1) != 0)
            it.ridx = 9'(recent_x + $urandom_range(0, 15) + FRAME_W * $urandom_range(0, PAGES - 1));
        else
            it.ridx = 9'($urandom);
        return it;
    endfunction

    // Present one item and hold it until the block takes it. Call it straight from a wait on posedge clk.
    task automatic issue(input cmd_row_t it);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= it.op;
        x_pos      <= it.x;
        y_pos      <= it.y;
        char_code  <= it.code;
        scale_x    <= it.sx;
        scale_y    <= it.sy;
        pixel_on   <= it.on;
        read_index <= it.ridx;
        // busy sampled here is the value from before the edge
        do @(posedge clk); while (busy);
        apply_item(it);
        if (it.op == CMD_PIXEL || it.op == CMD_SCALED || it.op == CMD_REPEAT)
            recent_x = it.x;
    endtask

    // Drop start, wait for every read to return and for the block to go idle,
    // then let it settle before anything touches the register.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_repeat_counts(input logic [27:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        repeat_mirror  = value;
    endtask

    // Compare each done strobe with the oldest outstanding read.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_bytes.size() == 0)
            begin
                report("frame_byte with no read outstanding", 8'h00, frame_byte);
            end
            else
            begin
                want_byte = pending_bytes.pop_front();
                if (frame_byte !== want_byte)
                    report("frame_byte", want_byte, frame_byte);
            end
        end
    end

    initial
    begin : stimulus
        logic [27:0] phase_counts [PHASES];
        // extremes first, then random settings, one of them with rows skipped, and one with every row one pixel tall
        phase_counts[0] = 28'hFFFFFFF;
        phase_counts[1] = 28'h0000000;
        phase_counts[2] = 28'($urandom);
        phase_counts[3] = 28'($urandom);
        for (int n = 0; n < GLYPH_H; n++)
            if ($urandom_range(0, 2) == 0)
                phase_counts[3][4*n +: 4] = 4'd0;
        phase_counts[4] = 28'h1111111;
        phase_counts[5] = 28'($urandom);

        foreach (frame_mirror[i])
            frame_mirror[i] = '0;
        repeat_mirror = REPEAT_RESET;

        // hold reset, then release it; the block then sweeps its store with busy high
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            issue(directed_rows[r]);
        drain();

        // random phases, each under its own repeat counts; no idling in the last one
        for (int p = 0; p < PHASES; p++)
        begin
            load_repeat_counts(phase_counts[p]);
            idle_enabled = (p != PHASES - 1);
            repeat (PHASE_ITEMS)
                issue(random_item());
            drain();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: several times a run in which every glyph takes its longest walk.
    initial
    begin : watchdog
        #400_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/sgr_pkg.sv
design/sgr_ram.sv
design/sgr_ctrl.sv
design/sgr_datapath.sv
design/scaled_glyph_rasterizer_unit.sv
design/sgr_checker.sv
test/testbench.sv
